// ===== design/postfix_expression_evaluator_defines.svh =====
// assertion macros shared by the postfix expression evaluator rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef POSTFIX_EXPRESSION_EVALUATOR_DEFINES_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define PFX_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define PFX_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/pfx_pkg.sv =====
// shared types and constants of the postfix expression evaluator
// no dependencies; imported by every module of the block
package pfx_pkg;

   // value stack sizing
   localparam int STACK_DEPTH = 16;
   localparam int PTR_W       = $clog2(STACK_DEPTH);
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int DATA_W      = 32;

   // token queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // radix-2 divider, one quotient bit per step
   localparam int DIV_STEPS  = DATA_W;
   localparam int DIV_STEP_W = $clog2(DIV_STEPS);

   // character codes
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_UNDERFLOW = 3'd1,
      ST_OVERFLOW  = 3'd2,
      ST_DIVZERO   = 3'd3,
      ST_BADCHAR   = 3'd4,
      ST_EMPTY     = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      TOK_NONE,
      TOK_ADD,
      TOK_SUB,
      TOK_MUL,
      TOK_DIV,
      TOK_BAD
   } token_type;

   // one classified item handed from front to back
   typedef struct packed {
      logic              has_num;
      logic [DATA_W-1:0] num;
      token_type         tok;
      logic              last;
   } entry_type;

   typedef enum logic [2:0] {
      BS_IDLE,
      BS_PUSH,
      BS_CLASS,
      BS_READ,
      BS_DIV,
      BS_WRITE,
      BS_FINISH,
      BS_EMIT
   } back_state_type;

   typedef struct packed {
      logic              start;
      logic [DATA_W-1:0] dividend;
      logic [DATA_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [DATA_W-1:0] quotient;
   } div_rsp_type;

endpackage

// ===== design/pfx_front.sv =====
// front end: accepts characters, builds operands from digit runs, classifies tokens
// depends on pfx_pkg
module pfx_front (
   input  logic                clock,
   input  logic                reset,
   input  logic [7:0]          req_char_code,
   input  logic                req_last_char,
   input  logic                req_push,
   output logic                req_full,
   output logic                q_push,
   output pfx_pkg::entry_type  q_entry,
   input  logic                q_full
);
   import pfx_pkg::*;

   logic [DATA_W-1:0] accum_ff, accum_in, accum_next;
   logic              in_num_ff, in_num_in;
   logic              is_digit;
   token_type         tok;
   logic              accept;
   logic [3:0]        digit;

   // character decoder
   always_comb begin
      is_digit = 1'b0;
      tok      = TOK_BAD;
      unique case (req_char_code) inside
         [CHAR_ZERO:CHAR_NINE]: begin
            is_digit = 1'b1;
            tok      = TOK_NONE;
         end
         CHAR_SPACE: tok = TOK_NONE;
         CHAR_PLUS:  tok = TOK_ADD;
         CHAR_MINUS: tok = TOK_SUB;
         CHAR_STAR:  tok = TOK_MUL;
         CHAR_SLASH: tok = TOK_DIV;
         default:    tok = TOK_BAD;
      endcase
   end

   // accum * 10 + digit, wrapping at 32 bits
   assign digit      = 4'(req_char_code - CHAR_ZERO);
   assign accum_next = (accum_ff << 3) + (accum_ff << 1) + {{(DATA_W-4){1'b0}}, digit};

   assign accept   = req_push && !q_full;
   assign req_full = q_full;
   assign q_push   = accept && (!is_digit || req_last_char);

   // item handed to the queue
   always_comb begin
      q_entry.has_num = in_num_ff || is_digit;
      q_entry.num     = is_digit ? accum_next : accum_ff;
      q_entry.tok     = tok;
      q_entry.last    = req_last_char;
   end

   // operand builder next state
   always_comb begin
      accum_in  = accum_ff;
      in_num_in = in_num_ff;
      if (q_push) begin
         accum_in  = '0;
         in_num_in = 1'b0;
      end else if (accept && is_digit) begin
         accum_in  = accum_next;
         in_num_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff  <= '0;
         in_num_ff <= 1'b0;
      end else begin
         accum_ff  <= accum_in;
         in_num_ff <= in_num_in;
      end
   end

endmodule

// ===== design/pfx_queue.sv =====
// short token queue that decouples the front end from the stack engine
// depends on pfx_pkg
module pfx_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  pfx_pkg::entry_type  push_entry,
   output logic                full,
   input  logic                pop,
   output pfx_pkg::entry_type  head_entry,
   output logic                empty
);
   import pfx_pkg::*;

   entry_type          slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  cnt_ff, cnt_in;
   logic               do_push, do_pop;

   assign full       = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty      = (cnt_ff == '0);
   assign head_entry = slots_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && !empty;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = do_push ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== design/pfx_div.sv =====
// iterative signed divider, truncating toward zero, one quotient bit per cycle
// depends on pfx_pkg
module pfx_div (
   input  logic                  clock,
   input  logic                  reset,
   input  pfx_pkg::div_req_type  div_req,
   output pfx_pkg::div_rsp_type  div_rsp
);
   import pfx_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic                  neg_ff, neg_in;
   logic [DATA_W-1:0]     quo_ff, quo_in;
   logic [DATA_W-1:0]     rem_ff, rem_in;
   logic [DATA_W-1:0]     dvs_ff, dvs_in;
   logic [DIV_STEP_W-1:0] step_ff, step_in;
   logic [DATA_W:0]       trial;
   logic [DATA_W-1:0]     mag_a, mag_b;

   // operand magnitudes
   assign mag_a = div_req.dividend[DATA_W-1] ? (~div_req.dividend + 1'b1) : div_req.dividend;
   assign mag_b = div_req.divisor[DATA_W-1]  ? (~div_req.divisor + 1'b1)  : div_req.divisor;

   // trial subtract of the shifted partial remainder
   assign trial = {rem_ff, quo_ff[DATA_W-1]} - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      step_in = step_ff;
      if (busy_ff) begin
         if (!trial[DATA_W]) begin
            rem_in = trial[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[DATA_W-2:0], quo_ff[DATA_W-1]};
            quo_in = {quo_ff[DATA_W-2:0], 1'b0};
         end
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - DIV_STEP_W'(1);
         end
      end else if (div_req.start) begin
         busy_in = 1'b1;
         neg_in  = div_req.dividend[DATA_W-1] ^ div_req.divisor[DATA_W-1];
         quo_in  = mag_a;
         rem_in  = '0;
         dvs_in  = mag_b;
         step_in = DIV_STEP_W'(DIV_STEPS - 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff  <= neg_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      step_ff <= step_in;
   end

   // sign correction of the result
   always_comb begin
      div_rsp.busy     = busy_ff;
      div_rsp.done     = done_ff;
      div_rsp.quotient = neg_ff ? (~quo_ff + 1'b1) : quo_ff;
   end

endmodule

// ===== design/pfx_back.sv =====
// back end: value stack, arithmetic sequencer, error tracking and result register
// depends on pfx_pkg, pfx_div and postfix_expression_evaluator_defines.svh
`include "postfix_expression_evaluator_defines.svh"

module pfx_back (
   input  logic                     clock,
   input  logic                     reset,
   input  pfx_pkg::entry_type       q_entry,
   input  logic                     q_empty,
   output logic                     q_pop,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output logic [pfx_pkg::DATA_W-1:0] rsp_value,
   output logic [2:0]               rsp_status
);
   import pfx_pkg::*;

   back_state_type    state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   status_type        err_ff, err_in;
   entry_type         entry_ff, entry_in;
   logic [DATA_W-1:0] res_ff, res_in;
   logic              out_valid_ff, out_valid_in;
   logic [DATA_W-1:0] out_value_ff, out_value_in;
   status_type        out_status_ff, out_status_in;

   logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
   logic [DATA_W-1:0] rd_rhs_ff, rd_lhs_ff;
   logic              mem_we;
   logic [PTR_W-1:0]  mem_waddr;
   logic [DATA_W-1:0] mem_wdata;
   logic [CNT_W-1:0]  cnt_m1, cnt_m2;
   logic [DATA_W-1:0] mul_lo;

   div_req_type       div_req;
   div_rsp_type       div_rsp;

   pfx_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign cnt_m1 = count_ff - CNT_W'(1);
   assign cnt_m2 = count_ff - CNT_W'(2);

   // value stack: one write port, two registered read ports at top and below top
   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[mem_waddr] <= mem_wdata;
      end
      rd_rhs_ff <= stack_mem[cnt_m1[PTR_W-1:0]];
      rd_lhs_ff <= stack_mem[cnt_m2[PTR_W-1:0]];
   end

   // low half of the product
   assign mul_lo = rd_lhs_ff * rd_rhs_ff;

   // sequencer next state and outputs
   always_comb begin
      state_in         = state_ff;
      count_in         = count_ff;
      err_in           = err_ff;
      entry_in         = entry_ff;
      res_in           = res_ff;
      q_pop            = 1'b0;
      mem_we           = 1'b0;
      mem_waddr        = count_ff[PTR_W-1:0];
      mem_wdata        = entry_ff.num;
      div_req.start    = 1'b0;
      div_req.dividend = rd_lhs_ff;
      div_req.divisor  = rd_rhs_ff;
      out_valid_in     = out_valid_ff && !rsp_pop;
      out_value_in     = out_value_ff;
      out_status_in    = out_status_ff;
      unique case (state_ff)
         BS_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               entry_in = q_entry;
               state_in = BS_PUSH;
            end
         end
         // push the pending operand
         BS_PUSH: begin
            if (err_ff == ST_OK && entry_ff.has_num) begin
               if (count_ff >= CNT_W'(STACK_DEPTH)) begin
                  err_in = ST_OVERFLOW;
               end else begin
                  mem_we   = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            state_in = BS_CLASS;
         end
         // operator check, stack reads issue here
         BS_CLASS: begin
            state_in = BS_FINISH;
            if (err_ff == ST_OK) begin
               unique case (entry_ff.tok) inside
                  TOK_ADD, TOK_SUB, TOK_MUL, TOK_DIV: begin
                     if (count_ff < CNT_W'(2)) begin
                        err_in = ST_UNDERFLOW;
                     end else begin
                        state_in = BS_READ;
                     end
                  end
                  TOK_BAD: err_in = ST_BADCHAR;
                  default: ;
               endcase
            end
         end
         // operands are in the read registers
         BS_READ: begin
            state_in = BS_WRITE;
            unique case (entry_ff.tok)
               TOK_ADD: res_in = rd_lhs_ff + rd_rhs_ff;
               TOK_SUB: res_in = rd_lhs_ff - rd_rhs_ff;
               TOK_MUL: res_in = mul_lo;
               TOK_DIV: begin
                  if (rd_rhs_ff == '0) begin
                     err_in   = ST_DIVZERO;
                     state_in = BS_FINISH;
                  end else begin
                     div_req.start = 1'b1;
                     state_in      = BS_DIV;
                  end
               end
               default: state_in = BS_FINISH;
            endcase
         end
         BS_DIV: begin
            if (div_rsp.done) begin
               res_in   = div_rsp.quotient;
               state_in = BS_WRITE;
            end
         end
         // pop two, push the result
         BS_WRITE: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_m2[PTR_W-1:0];
            mem_wdata = res_ff;
            count_in  = cnt_m1;
            state_in  = BS_FINISH;
         end
         BS_FINISH: begin
            state_in = entry_ff.last ? BS_EMIT : BS_IDLE;
         end
         // top of stack is in the read register; hand out the result and clear
         BS_EMIT: begin
            if (!out_valid_ff) begin
               out_valid_in = 1'b1;
               if (err_ff != ST_OK) begin
                  out_status_in = err_ff;
                  out_value_in  = '0;
               end else if (count_ff == '0) begin
                  out_status_in = ST_EMPTY;
                  out_value_in  = '0;
               end else begin
                  out_status_in = ST_OK;
                  out_value_in  = rd_rhs_ff;
               end
               count_in = '0;
               err_in   = ST_OK;
               state_in = BS_IDLE;
            end
         end
         default: state_in = BS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BS_IDLE;
         count_ff     <= '0;
         err_ff       <= ST_OK;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         err_ff       <= err_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff      <= entry_in;
      res_ff        <= res_in;
      out_value_ff  <= out_value_in;
      out_status_ff <= out_status_in;
   end

   assign rsp_empty  = !out_valid_ff;
   assign rsp_value  = out_value_ff;
   assign rsp_status = out_status_ff;

   // checks
   `PFX_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(STACK_DEPTH), "stack count beyond depth")
   `PFX_ASSERT_NOW(a_div_alive, clock, reset, state_ff == BS_DIV, div_rsp.busy || div_rsp.done, "waiting on an idle divider")
   `PFX_ASSERT_NEXT(a_emit_clears, clock, reset, state_ff == BS_EMIT && !out_valid_ff, count_ff == '0 && err_ff == ST_OK && out_valid_ff, "result load did not clear the stack")

endmodule

// ===== design/postfix_expression_evaluator.sv =====
// Postfix expression evaluator, top level; depends on pfx_pkg, pfx_front, pfx_queue and
// pfx_back (with pfx_div). Characters enter through a queue-style push/full port at up to
// one per cycle; digits only update the operand builder, while every other character and
// the last one become one item in a four-entry queue. The stack engine drains it: each
// item passes the idle, push, class and finish states; an operator also read and write,
// and a divide also waits in the div state on the radix-2 divider that yields one
// quotient bit per cycle; an expression's last item also passes the emit state. Input
// stalls (full) only when the queue fills. At the end mark one result (value and status)
// appears on the pop/empty port and waits there while the next expression enters.
module postfix_expression_evaluator (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [7:0]                 req_char_code,
   input  logic                       req_last_char,
   input  logic                       push,
   output logic                       full,
   output logic signed [pfx_pkg::DATA_W-1:0] rsp_value,
   output logic [2:0]                 rsp_status,
   output logic                       empty,
   input  logic                       pop
);
   import pfx_pkg::*;

   logic              q_push, q_full, q_pop, q_empty;
   entry_type         q_in_entry, q_head_entry;
   logic [DATA_W-1:0] value_bits;

   // character intake and classification
   pfx_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_char_code (req_char_code),
      .req_last_char (req_last_char),
      .req_push      (push),
      .req_full      (full),
      .q_push        (q_push),
      .q_entry       (q_in_entry),
      .q_full        (q_full)
   );

   // token queue
   pfx_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_in_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_entry (q_head_entry),
      .empty      (q_empty)
   );

   // stack engine and result register
   pfx_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_entry    (q_head_entry),
      .q_empty    (q_empty),
      .q_pop      (q_pop),
      .rsp_empty  (empty),
      .rsp_pop    (pop),
      .rsp_value  (value_bits),
      .rsp_status (rsp_status)
   );

   assign rsp_value = $signed(value_bits);

endmodule

// ===== bench/tb_postfix_expression_evaluator.sv =====
// self-checking bench for the postfix expression evaluator: directed and random expressions
// depends on pfx_pkg and postfix_expression_evaluator; checks against an in-bench calculator
`timescale 1ns / 100ps

module tb_postfix_expression_evaluator;
   import pfx_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 200;
   localparam int RANDOM_CHARS   = 1850;

   // one character item and one answer
   typedef struct {
      logic [7:0] code;
      logic       last;
   } char_item_type;

   typedef struct {
      logic [DATA_W-1:0] value;
      status_type        status;
   } answer_type;

   logic                     clock;
   logic                     reset;
   logic [7:0]               req_char_code = 8'd0;
   logic                     req_last_char = 1'b0;
   logic                     push = 1'b0;
   logic                     full;
   logic signed [DATA_W-1:0] rsp_value;
   logic [2:0]               rsp_status;
   logic                     empty;
   logic                     pop = 1'b0;

   char_item_type char_q[$];
   answer_type    answer_q[$];
   logic [7:0]    text_q[$];

   int total_chars;
   int total_answers;
   int sent_count;
   int answers_seen;
   int error_count;
   int stall_cycles;

   // calculator state
   logic [DATA_W-1:0] calc_stack [STACK_DEPTH];
   int                calc_depth;
   logic [DATA_W-1:0] calc_accum;
   bit                calc_in_num;
   status_type        calc_err;

   postfix_expression_evaluator DUT (
      .clock         (clock),
      .reset         (reset),
      .req_char_code (req_char_code),
      .req_last_char (req_last_char),
      .push          (push),
      .full          (full),
      .rsp_value     (rsp_value),
      .rsp_status    (rsp_status),
      .empty         (empty),
      .pop           (pop)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- calculator
   task clear_calc();
      calc_depth  = 0;
      calc_accum  = '0;
      calc_in_num = 0;
      calc_err    = ST_OK;
   endtask

   // first error of the expression sticks
   task raise_error(input status_type code);
      if (calc_err == ST_OK) calc_err = code;
   endtask

   task push_operand(input logic [DATA_W-1:0] v);
      if (calc_depth >= STACK_DEPTH) begin
         raise_error(ST_OVERFLOW);
      end else begin
         calc_stack[calc_depth] = v;
         calc_depth++;
      end
   endtask

   task flush_operand();
      if (calc_in_num) begin
         calc_in_num = 0;
         push_operand(calc_accum);
         calc_accum = '0;
      end
   endtask

   task evaluate_char(input logic [7:0] c, input logic last);
      answer_type        ans;
      logic [DATA_W-1:0] lhs, rhs, res, mag_l, mag_r, quo;
      bit                ok_op;
      if (calc_err == ST_OK) begin
         if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            calc_accum  = calc_accum * 32'd10 + {28'd0, c[3:0]};
            calc_in_num = 1;
         end else begin
            flush_operand();
            if (calc_err == ST_OK && c != CHAR_SPACE) begin
               if (c == CHAR_PLUS || c == CHAR_MINUS || c == CHAR_STAR || c == CHAR_SLASH) begin
                  if (calc_depth < 2) begin
                     raise_error(ST_UNDERFLOW);
                  end else begin
                     rhs   = calc_stack[calc_depth-1];
                     lhs   = calc_stack[calc_depth-2];
                     ok_op = 1;
                     res   = '0;
                     case (c)
                        CHAR_PLUS:  res = lhs + rhs;
                        CHAR_MINUS: res = lhs - rhs;
                        CHAR_STAR:  res = lhs * rhs;
                        default: begin
                           if (rhs == '0) begin
                              raise_error(ST_DIVZERO);
                              ok_op = 0;
                           end else begin
                              // magnitudes, then sign: truncates toward zero
                              mag_l = lhs[DATA_W-1] ? -lhs : lhs;
                              mag_r = rhs[DATA_W-1] ? -rhs : rhs;
                              quo   = mag_l / mag_r;
                              res   = (lhs[DATA_W-1] ^ rhs[DATA_W-1]) ? -quo : quo;
                           end
                        end
                     endcase
                     if (ok_op) begin
                        calc_depth -= 2;
                        push_operand(res);
                     end
                  end
               end else begin
                  raise_error(ST_BADCHAR);
               end
            end
         end
      end
      // end mark: one answer, then start afresh
      if (last) begin
         if (calc_err == ST_OK) flush_operand();
         ans.value = '0;
         if (calc_err != ST_OK) begin
            ans.status = calc_err;
         end else if (calc_depth == 0) begin
            ans.status = ST_EMPTY;
         end else begin
            ans.status = ST_OK;
            ans.value  = calc_stack[calc_depth-1];
         end
         answer_q.push_back(ans);
         clear_calc();
      end
   endtask

   // ---------------------------------------------------------------- expression text
   task add_string(input string s);
      for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
   endtask

   task add_number();
      int r, n;
      r = $urandom_range(0, 99);
      if (r < 5)       n = 0;
      else if (r < 50) n = $urandom_range(1, 2);
      else if (r < 75) n = $urandom_range(3, 5);
      else if (r < 90) n = $urandom_range(6, 10);
      else             n = $urandom_range(11, 14);
      if (n == 0) text_q.push_back(CHAR_ZERO);
      for (int i = 0; i < n; i++) text_q.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
   endtask

   task add_operator();
      int r;
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 30) text_q.push_back(CHAR_SPACE);
      if (r < 25)      text_q.push_back(CHAR_PLUS);
      else if (r < 50) text_q.push_back(CHAR_MINUS);
      else if (r < 75) text_q.push_back(CHAR_STAR);
      else             text_q.push_back(CHAR_SLASH);
   endtask

   // move the text into the item queue, end mark on its final character
   task commit_expr();
      char_item_type it;
      for (int i = 0; i < text_q.size(); i++) begin
         it.code = text_q[i];
         it.last = (i == text_q.size() - 1);
         char_q.push_back(it);
      end
      text_q.delete();
   endtask

   // well-formed expression; deep ones stack every operand before any operator
   task gen_well_formed();
      int  n, used, depth;
      bit  deep, prev_num, stop_early;
      deep       = ($urandom_range(0, 99) < 10);
      n          = deep ? $urandom_range(14, 17) : $urandom_range(1, 6);
      used       = 0;
      depth      = 0;
      prev_num   = 0;
      stop_early = 0;
      while (used < n || (depth > 1 && !stop_early)) begin
         if (used < n && (depth < 2 || deep || $urandom_range(0, 1))) begin
            if (prev_num) text_q.push_back(CHAR_SPACE);
            else if (text_q.size() > 0 && $urandom_range(0, 99) < 30)
               text_q.push_back(CHAR_SPACE);
            add_number();
            depth++;
            used++;
            prev_num = 1;
         end else begin
            add_operator();
            depth--;
            prev_num = 0;
            if (used == n && $urandom_range(0, 99) < 8) stop_early = 1;
         end
      end
      if ($urandom_range(0, 99) < 10) text_q.push_back(CHAR_SPACE);
      commit_expr();
   endtask

   // broken sequences from the legal alphabet with an odd stray character
   task gen_broken();
      int n, r;
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 45)      text_q.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
         else if (r < 65) text_q.push_back(CHAR_SPACE);
         else if (r < 92) add_operator();
         else             text_q.push_back(8'($urandom_range(0, 255)));
      end
      commit_expr();
   endtask

   task gen_noise();
      int n;
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) text_q.push_back(8'($urandom_range(0, 255)));
      commit_expr();
   endtask

   task build_stimulus();
      int r;
      // directed expressions
      add_string("9");                   commit_expr();
      add_string("4294967295");          commit_expr();
      add_string("4294967296");          commit_expr();
      add_string("12 34+");              commit_expr();
      add_string("100 7 -");             commit_expr();
      add_string("65536 65536 *");       commit_expr();
      add_string("0 7 - 2 /");           commit_expr();
      add_string("2147483648 0 1 - /");  commit_expr();
      add_string("7 0 /");               commit_expr();
      add_string("+");                   commit_expr();
      add_string("5 *");                 commit_expr();
      add_string("1 2 3");               commit_expr();
      add_string(" ");                   commit_expr();
      add_string("12a 3");               commit_expr();
      add_string("+ 1 2 #");             commit_expr();
      add_string("3 4+ ");               commit_expr();
      add_string("8 2/ 3-");             commit_expr();
      add_string("42");
      text_q.push_back(8'hFF);           commit_expr();
      // exactly full stack, then one too many, then overflow before an operator
      for (int i = 0; i < STACK_DEPTH; i++) add_string("1 ");
      for (int i = 1; i < STACK_DEPTH; i++) add_string("+");
      commit_expr();
      for (int i = 0; i <= STACK_DEPTH; i++) add_string("2 ");
      commit_expr();
      for (int i = 0; i <= STACK_DEPTH + 1; i++) add_string("3 ");
      add_string("+");
      commit_expr();
      // random expressions
      while (char_q.size() < RANDOM_CHARS) begin
         r = $urandom_range(0, 99);
         if (r < 80)      gen_well_formed();
         else if (r < 92) gen_broken();
         else             gen_noise();
      end
   endtask

   // ---------------------------------------------------------------- driver
   always @(posedge clock) begin
      int idle_pct;
      int phase;
      phase = (total_chars == 0) ? 0 : (sent_count * 4) / total_chars;
      case (phase)
         1:       idle_pct = 75;
         3:       idle_pct = 23;
         default: idle_pct = 0;
      endcase
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (push && !full) begin
            evaluate_char(req_char_code, req_last_char);
            void'(char_q.pop_front());
            sent_count++;
         end
         // an item refused by full stays on the ports
         if (!(push && full)) begin
            if (char_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
               push          <= 1'b1;
               req_char_code <= char_q[0].code;
               req_last_char <= char_q[0].last;
            end else begin
               push <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor
   always @(posedge clock) begin
      answer_type exp_ans;
      int         stall_pct;
      int         phase;
      phase = (total_answers == 0) ? 0 : (answers_seen * 4) / total_answers;
      case (phase)
         2:       stall_pct = 75;
         3:       stall_pct = 23;
         default: stall_pct = 0;
      endcase
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            answers_seen++;
            if (answer_q.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("unexpected result: value %h status %0d", rsp_value, rsp_status);
            end else begin
               exp_ans = answer_q.pop_front();
               if (rsp_value !== exp_ans.value || rsp_status !== exp_ans.status) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("mismatch: value exp %h got %h, status exp %0d got %0d",
                              exp_ans.value, rsp_value, exp_ans.status, rsp_status);
               end
            end
         end
         pop <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // ---------------------------------------------------------------- watchdog
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- sequence
   initial begin
      reset         = 1'b1;
      stall_cycles  = 0;
      sent_count    = 0;
      answers_seen  = 0;
      error_count   = 0;
      total_chars   = 0;
      total_answers = 0;
      clear_calc();
      build_stimulus();
      total_chars = char_q.size();
      foreach (char_q[i]) if (char_q[i].last) total_answers++;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      while (char_q.size() > 0 || push) @(posedge clock);
      while (answer_q.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (answer_q.size() > 0) begin
         error_count++;
         $display("%0d expected results never arrived", answer_q.size());
      end
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
